// File: rtl/core/gffra_pkg.sv
// Shared constants and types of the grid first-fit rectangle allocator.
// Used by the cell RAM user, the column fit search and the top level; no dependencies.
package gffra_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int MAX_ROWS    = 16;
    localparam int ID_BITS     = 8;

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COLS_CW    = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_CW    = $clog2(MAX_ROWS + 1);

    // size fields of requests and of the grid registers
    localparam int DIM_W = 5;
    localparam int SUM_W = $clog2(MAX_COLUMNS + MAX_ROWS + 2 ** DIM_W) + 1;
    localparam int POS_W = 4;

    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [DIM_W-1:0] GRID_RESET = DIM_W'(16);

    typedef enum logic {
        REQ_PLACE  = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic {
        REG_GRID_COLUMNS = 1'b0,
        REG_GRID_ROWS    = 1'b1
    } t_reg;

    typedef struct packed {
        logic             found;
        logic [COL_W-1:0] col;
    } t_fit;

endpackage

// File: rtl/core/grid_first_fit_rect_allocator.sv
// Grid first-fit rectangle allocator: request channel, response channel, APB config port.
// Depends on gffra_pkg, gffra_ram and gffra_fit.
//
// Usage:
//   A request (type, id, width, height) is taken when i_req_valid and o_req_ready
//   are high; o_req_ready is high only while the sequencer is idle. Each request
//   gives exactly one response (ok, pos_col, pos_row, turned) on o_rsp_valid.
//   Place: rows are scanned top to bottom; each candidate row ORs h occupancy rows
//   into one mask (S_ACC), then runs the column search on it (S_FIT). A failed scan
//   retries once with width and height swapped. A hit fills w*h cells, one RAM write
//   per cycle. The shared row accumulator and the single RAM write port set the
//   speed of a place.
//   Remove: a sweep over all CELL_COUNT cells, the compare running one cell behind
//   the RAM read, then a drain state.
//   A request with id zero, or a place with a zero size, goes straight to S_DONE.
//   Reset clears every occupancy bit at once, so the grid reads empty with no
//   clearing pass, and sets both grid sizes to 16.
//   The response sits in an output register; the next request is taken while it
//   waits, and the block stalls only when a second response is ready before the
//   first was taken.
//   Grid sizes are written over APB (columns at 0x0, rows at 0x4). The user must
//   write them only while idle; the block itself does not enforce this.
module grid_first_fit_rect_allocator
    import gffra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic                  i_req_type,
    input  logic [7:0]            i_item_id,
    input  logic [DIM_W-1:0]      i_item_width,
    input  logic [DIM_W-1:0]      i_item_height,

    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output logic                  o_ok,
    output logic [POS_W-1:0]      o_pos_col,
    output logic [POS_W-1:0]      o_pos_row,
    output logic                  o_turned,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ROW   = 8'b0000_0010,
        S_ACC   = 8'b0000_0100,
        S_FIT   = 8'b0000_1000,
        S_FILL  = 8'b0001_0000,
        S_CLR   = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col));
    endfunction

    t_state                 r_state, n_state;
    logic [DIM_W-1:0]       r_cfg_cols, r_cfg_rows;
    logic [MAX_COLUMNS-1:0] r_occ [MAX_ROWS];
    logic [MAX_COLUMNS-1:0] n_occ [MAX_ROWS];
    logic [ID_BITS-1:0]     r_id, n_id;
    logic [DIM_W-1:0]       r_w, n_w, r_h, n_h;
    logic                   r_turned, n_turned;
    logic                   r_res_ok, n_res_ok;
    logic [ROWS_CW-1:0]     r_r0, n_r0;
    logic [ROW_W-1:0]       r_y, n_y;
    logic [MAX_COLUMNS-1:0] r_acc, n_acc;
    logic [COL_W-1:0]       r_pc, n_pc, r_fx, n_fx, r_c, n_c, r_chk_c, n_chk_c;
    logic [ROW_W-1:0]       r_pr, n_pr, r_fy, n_fy, r_r, n_r, r_chk_r, n_chk_r;
    logic                   r_chk_valid, n_chk_valid;
    logic                   r_out_valid, n_out_valid;
    logic                   r_ok, n_ok, r_out_turned, n_out_turned;
    logic [POS_W-1:0]       r_pos_col, n_pos_col, r_pos_row, n_pos_row;

    logic [COLS_CW-1:0]     used_cols;
    logic [ROWS_CW-1:0]     used_rows;
    logic [ROW_W-1:0]       acc_row, fill_row;
    logic [COL_W-1:0]       fill_col;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [ID_BITS-1:0]     ram_rdata;
    logic                   cfg_wr;
    t_reg                   cfg_reg;
    t_fit                   fit;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_reg = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= GRID_RESET;
            r_cfg_rows <= GRID_RESET;
        end else if (cfg_wr) begin
            case (cfg_reg)
                REG_GRID_COLUMNS: r_cfg_cols <= pwdata[DIM_W-1:0];
                REG_GRID_ROWS:    r_cfg_rows <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg)
            REG_GRID_COLUMNS: prdata = CFG_DATA_W'(r_cfg_cols);
            REG_GRID_ROWS:    prdata = CFG_DATA_W'(r_cfg_rows);
            default:          prdata = '0;
        endcase
    end

    assign used_cols = (SUM_W'(r_cfg_cols) > SUM_W'(MAX_COLUMNS)) ? COLS_CW'(MAX_COLUMNS)
                                                                 : COLS_CW'(r_cfg_cols);
    assign used_rows = (SUM_W'(r_cfg_rows) > SUM_W'(MAX_ROWS)) ? ROWS_CW'(MAX_ROWS)
                                                              : ROWS_CW'(r_cfg_rows);

    // ---------------- datapath ----------------
    assign acc_row  = ROW_W'(SUM_W'(r_r0) + SUM_W'(r_y));
    assign fill_row = ROW_W'(SUM_W'(r_pr) + SUM_W'(r_fy));
    assign fill_col = COL_W'(SUM_W'(r_pc) + SUM_W'(r_fx));
    assign ram_waddr = cell_addr(fill_row, fill_col);
    assign ram_raddr = cell_addr(r_r, r_c);

    gffra_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_id),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gffra_fit u_fit (
        .i_busy  (r_acc),
        .i_width (r_w),
        .i_cols  (used_cols),
        .o_fit   (fit)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_id         = r_id;
        n_w          = r_w;
        n_h          = r_h;
        n_turned     = r_turned;
        n_res_ok     = r_res_ok;
        n_r0         = r_r0;
        n_y          = r_y;
        n_acc        = r_acc;
        n_pc         = r_pc;
        n_pr         = r_pr;
        n_fx         = r_fx;
        n_fy         = r_fy;
        n_c          = r_c;
        n_r          = r_r;
        n_chk_c      = r_chk_c;
        n_chk_r      = r_chk_r;
        n_chk_valid  = 1'b0;
        n_ok         = r_ok;
        n_pos_col    = r_pos_col;
        n_pos_row    = r_pos_row;
        n_out_turned = r_out_turned;
        n_out_valid  = r_out_valid && !i_rsp_ready;
        ram_we       = 1'b0;

        // remove compare stage, one cell behind the RAM read
        if (r_chk_valid && r_occ[r_chk_r][r_chk_c] && (ram_rdata == r_id)) begin
            n_occ[r_chk_r][r_chk_c] = 1'b0;
            n_res_ok                = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_id     = ID_BITS'(i_item_id);
                    n_w      = i_item_width;
                    n_h      = i_item_height;
                    n_turned = 1'b0;
                    n_res_ok = 1'b0;
                    n_pc     = '0;
                    n_pr     = '0;
                    n_r0     = '0;
                    n_r      = '0;
                    n_c      = '0;
                    if (ID_BITS'(i_item_id) == '0) begin
                        n_state = S_DONE;
                    end else if (t_req'(i_req_type) == REQ_REMOVE) begin
                        n_state = S_CLR;
                    end else if (i_item_width == '0 || i_item_height == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ROW;
                    end
                end
            end
            S_ROW: begin
                if (SUM_W'(r_r0) + SUM_W'(r_h) > SUM_W'(used_rows)) begin
                    // scan exhausted: retry swapped once, then give up
                    if (!r_turned) begin
                        n_turned = 1'b1;
                        n_w      = r_h;
                        n_h      = r_w;
                        n_r0     = '0;
                    end else begin
                        n_res_ok = 1'b0;
                        n_pc     = '0;
                        n_pr     = '0;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_acc   = '0;
                    n_y     = '0;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_acc = r_acc | r_occ[acc_row];
                if (SUM_W'(r_y) + SUM_W'(1) == SUM_W'(r_h)) begin
                    n_state = S_FIT;
                end else begin
                    n_y = ROW_W'(SUM_W'(r_y) + SUM_W'(1));
                end
            end
            S_FIT: begin
                if (fit.found) begin
                    n_pc    = fit.col;
                    n_pr    = ROW_W'(r_r0);
                    n_fx    = '0;
                    n_fy    = '0;
                    n_state = S_FILL;
                end else begin
                    n_r0    = ROWS_CW'(SUM_W'(r_r0) + SUM_W'(1));
                    n_state = S_ROW;
                end
            end
            S_FILL: begin
                ram_we                  = 1'b1;
                n_occ[fill_row][fill_col] = 1'b1;
                if (SUM_W'(r_fx) + SUM_W'(1) == SUM_W'(r_w)) begin
                    n_fx = '0;
                    if (SUM_W'(r_fy) + SUM_W'(1) == SUM_W'(r_h)) begin
                        n_res_ok = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_fy = ROW_W'(SUM_W'(r_fy) + SUM_W'(1));
                    end
                end else begin
                    n_fx = COL_W'(SUM_W'(r_fx) + SUM_W'(1));
                end
            end
            S_CLR: begin
                n_chk_valid = 1'b1;
                n_chk_c     = r_c;
                n_chk_r     = r_r;
                if (r_c == COL_W'(MAX_COLUMNS - 1)) begin
                    n_c = '0;
                    if (r_r == ROW_W'(MAX_ROWS - 1)) begin
                        n_r     = '0;
                        n_state = S_DRAIN;
                    end else begin
                        n_r = ROW_W'(SUM_W'(r_r) + SUM_W'(1));
                    end
                end else begin
                    n_c = COL_W'(SUM_W'(r_c) + SUM_W'(1));
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_rsp_ready) begin
                    n_out_valid  = 1'b1;
                    n_ok         = r_res_ok;
                    n_pos_col    = POS_W'(r_pc);
                    n_pos_row    = POS_W'(r_pr);
                    n_out_turned = r_turned;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '{default: '0};
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_w          <= n_w;
        r_h          <= n_h;
        r_turned     <= n_turned;
        r_res_ok     <= n_res_ok;
        r_r0         <= n_r0;
        r_y          <= n_y;
        r_acc        <= n_acc;
        r_pc         <= n_pc;
        r_pr         <= n_pr;
        r_fx         <= n_fx;
        r_fy         <= n_fy;
        r_c          <= n_c;
        r_r          <= n_r;
        r_chk_c      <= n_chk_c;
        r_chk_r      <= n_chk_r;
        r_ok         <= n_ok;
        r_pos_col    <= n_pos_col;
        r_pos_row    <= n_pos_row;
        r_out_turned <= n_out_turned;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_pos_col   = r_pos_col;
    assign o_pos_row   = r_pos_row;
    assign o_turned    = r_out_turned;

endmodule

// File: rtl/core/gffra_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; contents are undefined until written.
module gffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/gffra_fit.sv
// Column search: first column where a window of the given width is free in a row mask.
// Depends on gffra_pkg.
module gffra_fit
    import gffra_pkg::*;
(
    input  logic [MAX_COLUMNS-1:0] i_busy,
    input  logic [DIM_W-1:0]       i_width,
    input  logic [COLS_CW-1:0]     i_cols,
    output t_fit                   o_fit
);

    logic [MAX_COLUMNS-1:0] c_free;

    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
        logic [MAX_COLUMNS-1:0] win;
        for (genvar b = 0; b < MAX_COLUMNS; b++) begin : g_bit
            assign win[b] = (b >= c) && (SUM_W'(b) < SUM_W'(c) + SUM_W'(i_width));
        end
        assign c_free[c] = (SUM_W'(c) + SUM_W'(i_width) <= SUM_W'(i_cols))
                           && ((i_busy & win) == '0);
    end

    // lowest free column wins
    always_comb begin
        o_fit = '0;
        for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
            if (c_free[c]) begin
                o_fit.found = 1'b1;
                o_fit.col   = COL_W'(c);
            end
        end
    end

endmodule

// File: bench/tb_grid_first_fit_rect_allocator.sv
// Testbench for grid_first_fit_rect_allocator: random and directed place/remove requests,
// checked against a first-fit occupancy predictor, with grid sizes written over APB.
// Depends on gffra_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_grid_first_fit_rect_allocator;
    import gffra_pkg::*;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             turned;
    } t_alloc_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_req_valid   = 1'b0;
    logic                  i_req_type    = 1'b0;
    logic [7:0]            i_item_id     = '0;
    logic [DIM_W-1:0]      i_item_width  = '0;
    logic [DIM_W-1:0]      i_item_height = '0;
    logic                  i_rsp_ready   = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [PADDR_W-1:0]    paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic                  o_req_ready;
    logic                  o_rsp_valid;
    logic                  o_ok;
    logic [POS_W-1:0]      o_pos_col;
    logic [POS_W-1:0]      o_pos_row;
    logic                  o_turned;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state: owner id per cell and the grid size registers
    logic [ID_BITS-1:0] grid_owner [CELL_COUNT];
    logic [DIM_W-1:0]   grid_cols_cfg;
    logic [DIM_W-1:0]   grid_rows_cfg;

    t_alloc_result pending_results [$];
    int            fail_count      = 0;
    bit            req_idle_on     = 1'b1;
    bit            rsp_idle_on     = 1'b1;
    int            rsp_hold_cycles = 0;

    grid_first_fit_rect_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_req_type    (i_req_type),
        .i_item_id     (i_item_id),
        .i_item_width  (i_item_width),
        .i_item_height (i_item_height),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .o_ok          (o_ok),
        .o_pos_col     (o_pos_col),
        .o_pos_row     (o_pos_row),
        .o_turned      (o_turned),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int cols_in_use();
        return (grid_cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : int'(grid_cols_cfg);
    endfunction

    function automatic int rows_in_use();
        return (grid_rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(grid_rows_cfg);
    endfunction

    function automatic bit window_empty(int c0, int r0, int w, int h);
        if (c0 + w > cols_in_use() || r0 + h > rows_in_use())
            return 1'b0;
        for (int r = r0; r < r0 + h; r++)
            for (int c = c0; c < c0 + w; c++)
                if (grid_owner[r * MAX_COLUMNS + c] != '0)
                    return 1'b0;
        return 1'b1;
    endfunction

    // row-major first fit; claims the window on a hit
    function automatic bit claim_first_fit(logic [7:0] id, int w, int h,
                                           output int pc, output int pr);
        pc = 0;
        pr = 0;
        for (int r = 0; r < rows_in_use(); r++) begin
            for (int c = 0; c < cols_in_use(); c++) begin
                if (window_empty(c, r, w, h)) begin
                    for (int y = r; y < r + h; y++)
                        for (int x = c; x < c + w; x++)
                            grid_owner[y * MAX_COLUMNS + x] = id[ID_BITS-1:0];
                    pc = c;
                    pr = r;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_alloc_result predict_request(t_req kind, logic [7:0] id,
                                                      logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        t_alloc_result res;
        int            pc;
        int            pr;
        res = '0;
        if (id != '0) begin
            if (kind == REQ_REMOVE) begin
                for (int i = 0; i < CELL_COUNT; i++) begin
                    if (grid_owner[i] == id[ID_BITS-1:0]) begin
                        grid_owner[i] = '0;
                        res.ok = 1'b1;
                    end
                end
            end else if (w != '0 && h != '0) begin
                if (claim_first_fit(id, int'(w), int'(h), pc, pr)) begin
                    res.ok = 1'b1;
                end else begin
                    // retry with the rectangle turned
                    res.turned = 1'b1;
                    res.ok = claim_first_fit(id, int'(h), int'(w), pc, pr);
                end
                if (res.ok) begin
                    res.col = pc[POS_W-1:0];
                    res.row = pr[POS_W-1:0];
                end
            end
        end
        return res;
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 78)
            return DIM_W'($urandom_range(1, 4));
        if (roll < 95)
            return DIM_W'($urandom_range(1, 16));
        return DIM_W'($urandom_range(0, 31));
    endfunction

    function automatic void check_response();
        t_alloc_result want;
        if (pending_results.size() == 0) begin
            $error("response with no request pending: ok=%0d col=%0d row=%0d turned=%0d",
                   o_ok, o_pos_col, o_pos_row, o_turned);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (o_ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, o_ok);
            fail_count++;
        end
        if (o_pos_col !== want.col) begin
            $error("pos_col: expected %0d, got %0d", want.col, o_pos_col);
            fail_count++;
        end
        if (o_pos_row !== want.row) begin
            $error("pos_row: expected %0d, got %0d", want.row, o_pos_row);
            fail_count++;
        end
        if (o_turned !== want.turned) begin
            $error("turned: expected %0d, got %0d", want.turned, o_turned);
            fail_count++;
        end
    endfunction

    // Returns at the edge that takes the request; the caller either sends the next one
    // in the same step or drains.
    task automatic send_request(t_req kind, logic [7:0] id,
                                logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        int gap;
        gap = req_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid   <= 1'b1;
        i_req_type    <= kind;
        i_item_id     <= id;
        i_item_width  <= w;
        i_item_height <= h;
        do @(posedge i_clk); while (!o_req_ready);
        pending_results.push_back(predict_request(kind, id, w, h));
    endtask

    task automatic drain_requests();
        if (i_req_valid)
            i_req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_grid_reg(t_reg idx, logic [DIM_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= {27'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GRID_COLUMNS)
            grid_cols_cfg = value;
        else
            grid_rows_cfg = value;
    endtask

    task automatic set_grid(logic [DIM_W-1:0] cols, logic [DIM_W-1:0] rows);
        write_grid_reg(REG_GRID_COLUMNS, cols);
        write_grid_reg(REG_GRID_ROWS, rows);
    endtask

    // full-grid fill, oversize, zero sizes, id zero, turned fits and duplicate ids
    task automatic test_default_grid();
        send_request(REQ_PLACE, 8'd1, 5'd16, 5'd16);
        send_request(REQ_PLACE, 8'd2, 5'd1, 5'd1);
        send_request(REQ_REMOVE, 8'd1, 5'd0, 5'd0);
        send_request(REQ_REMOVE, 8'd1, 5'd31, 5'd31);
        send_request(REQ_PLACE, 8'd0, 5'd3, 5'd3);
        send_request(REQ_REMOVE, 8'd0, 5'd3, 5'd3);
        send_request(REQ_PLACE, 8'd3, 5'd0, 5'd4);
        send_request(REQ_PLACE, 8'd3, 5'd4, 5'd0);
        send_request(REQ_PLACE, 8'd4, 5'd31, 5'd1);
        send_request(REQ_PLACE, 8'd255, 5'd16, 5'd1);
        send_request(REQ_PLACE, 8'd5, 5'd1, 5'd16);
        send_request(REQ_PLACE, 8'd6, 5'd3, 5'd5);
        send_request(REQ_PLACE, 8'd6, 5'd2, 5'd2);
        send_request(REQ_REMOVE, 8'd6, 5'd0, 5'd0);
        send_request(REQ_REMOVE, 8'd255, 5'd0, 5'd0);
        send_request(REQ_REMOVE, 8'd5, 5'd0, 5'd0);
        drain_requests();
    endtask

    // small, zero and saturated grid sizes; cells kept across resizes; remove outside the grid
    task automatic test_grid_registers();
        set_grid(5'd4, 5'd4);
        send_request(REQ_PLACE, 8'd9, 5'd4, 5'd4);
        send_request(REQ_PLACE, 8'd10, 5'd1, 5'd1);
        drain_requests();
        set_grid(5'd16, 5'd16);
        send_request(REQ_PLACE, 8'd11, 5'd5, 5'd1);
        drain_requests();
        set_grid(5'd0, 5'd16);
        send_request(REQ_PLACE, 8'd12, 5'd1, 5'd1);
        drain_requests();
        set_grid(5'd31, 5'd1);
        send_request(REQ_PLACE, 8'd13, 5'd7, 5'd1);
        drain_requests();
        set_grid(5'd1, 5'd1);
        send_request(REQ_PLACE, 8'd14, 5'd1, 5'd1);
        send_request(REQ_REMOVE, 8'd9, 5'd0, 5'd0);
        send_request(REQ_PLACE, 8'd14, 5'd1, 5'd1);
        send_request(REQ_REMOVE, 8'd11, 5'd0, 5'd0);
        send_request(REQ_REMOVE, 8'd13, 5'd0, 5'd0);
        send_request(REQ_REMOVE, 8'd14, 5'd0, 5'd0);
        drain_requests();
        set_grid(5'd16, 5'd31);
    endtask

    // hold the response side for a long stretch while requests keep coming
    task automatic test_response_backpressure();
        req_idle_on     = 1'b0;
        rsp_hold_cycles = 2500;
        for (int k = 0; k < 11; k++) begin
            if (k % 2 == 0)
                send_request(REQ_PLACE, 8'd0, 5'd2, 5'd2);
            else
                send_request(REQ_PLACE, 8'd200, 5'd1, 5'd1);
        end
        send_request(REQ_REMOVE, 8'd200, 5'd0, 5'd0);
        drain_requests();
    endtask

    task automatic test_random_traffic();
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] rows;
        logic [7:0]       id;
        t_req             kind;
        int               pool_base;
        int               roll;
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: begin cols = 5'd16; rows = 5'd16; end
                1: begin cols = 5'd1;  rows = 5'd1;  end
                2: begin cols = 5'd0;  rows = DIM_W'($urandom_range(1, 16)); end
                3: begin cols = DIM_W'($urandom_range(1, 16)); rows = 5'd0; end
                4: begin cols = 5'd31; rows = 5'd31; end
                5: begin cols = 5'd1;  rows = 5'd16; end
                6: begin cols = 5'd16; rows = 5'd1;  end
                7: begin
                    cols = DIM_W'($urandom_range(1, 16));
                    rows = DIM_W'($urandom_range(1, 16));
                end
                default: begin
                    cols = DIM_W'($urandom_range(0, 31));
                    rows = DIM_W'($urandom_range(0, 31));
                end
            endcase
            set_grid(cols, rows);
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            // ids of a phase come from a small pool so removes find their rectangles
            pool_base = $urandom_range(1, 243);
            repeat (77) begin
                roll = $urandom_range(0, 99);
                id   = 8'(pool_base + $urandom_range(0, 12));
                if (roll < 60) begin
                    kind = REQ_PLACE;
                end else if (roll < 84) begin
                    kind = REQ_REMOVE;
                end else if (roll < 90) begin
                    kind = REQ_REMOVE;
                    id   = 8'($urandom_range(0, 255));
                end else begin
                    kind = t_req'($urandom_range(0, 1));
                    id   = '0;
                end
                send_request(kind, id, pick_size(), pick_size());
            end
            // clear the pool before the grid is resized
            for (int k = 0; k < 13; k++)
                send_request(REQ_REMOVE, 8'(pool_base + k), DIM_W'($urandom_range(0, 31)),
                             DIM_W'($urandom_range(0, 31)));
            drain_requests();
        end
    endtask

    initial begin : response_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rsp_hold_cycles > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge i_clk);
                rsp_hold_cycles = 0;
            end
            stall = rsp_idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (!o_rsp_valid);
            check_response();
        end
    end

    initial begin
        #50_000_000;
        $display("grid_first_fit_rect_allocator: mismatch");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < CELL_COUNT; i++)
            grid_owner[i] = '0;
        grid_cols_cfg = GRID_RESET;
        grid_rows_cfg = GRID_RESET;

        test_default_grid();
        test_grid_registers();
        test_response_backpressure();
        test_random_traffic();

        drain_requests();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("grid_first_fit_rect_allocator: match");
        else
            $display("grid_first_fit_rect_allocator: mismatch");
        $finish;
    end

endmodule
